// ===== hw/rtl/weighted_recent_contribution_score_macros.svh =====
// Assertion macros shared by the checker of the recent contribution score block.
`ifndef WEIGHTED_RECENT_CONTRIBUTION_SCORE_MACROS_SVH
`define WEIGHTED_RECENT_CONTRIBUTION_SCORE_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define WRCS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define WRCS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/wrcs_pkg.sv =====
// Types, constants and helpers of the recent contribution score block.
package wrcs_pkg;

  // Table geometry
  localparam int NUM_ALGORITHMS     = 4;
  localparam int NUM_CONFIGURATIONS = 8;
  localparam int HISTORY_DEPTH      = 16;
  localparam int ENTRIES            = NUM_ALGORITHMS * NUM_CONFIGURATIONS;

  // Field widths
  localparam int CMD_W   = 2;
  localparam int ALG_W   = 2;
  localparam int CONF_W  = 3;
  localparam int VAL_W   = 16;
  localparam int RND_W   = 16;
  localparam int WIN_W   = 5;
  localparam int THR_W   = 16;
  localparam int KIND_W  = 2;
  localparam int MEAN_W  = 24;
  localparam int FRAC_W  = 8;
  localparam int RUN_W   = 8;
  localparam int RUN_MAX = 255;
  localparam int TALLY_W = 2;

  // Derived widths
  localparam int ENTRY_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int POS_W    = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int FILL_W   = $clog2(HISTORY_DEPTH + 1);
  localparam int HADDR_W  = (ENTRIES * HISTORY_DEPTH > 1) ? $clog2(ENTRIES * HISTORY_DEPTH) : 1;
  localparam int WSUM_MAX = HISTORY_DEPTH * (HISTORY_DEPTH + 1) / 2;
  localparam int WSUM_W   = $clog2(WSUM_MAX + 1);
  localparam int SUM_W    = VAL_W + WSUM_W;
  localparam int DIVD_W   = SUM_W + FRAC_W;
  localparam int DCNT_W   = $clog2(DIVD_W + 1);

  // Configuration port
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;
  localparam logic REG_WINDOW = 1'b0;
  localparam logic REG_THRESH = 1'b1;
  localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(4);

  typedef enum logic [CMD_W-1:0] {
    CMD_BEGIN    = 2'd0,
    CMD_END      = 2'd1,
    CMD_RECORD   = 2'd2,
    CMD_ESTIMATE = 2'd3
  } cmd_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_HUGE = 2'd0,
    KIND_TINY = 2'd1,
    KIND_ONE  = 2'd2,
    KIND_MEAN = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_META,
    ST_SUM,
    ST_START,
    ST_DIV,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [RUN_W-1:0]  running;
    logic [FILL_W-1:0] fill;
    logic [POS_W-1:0]  wptr;
  } meta_t;

  typedef struct packed {
    logic [WIN_W-1:0] window_length;
    logic [THR_W-1:0] random_threshold;
  } cfg_t;

  typedef struct packed {
    logic              start;
    logic [DIVD_W-1:0] dividend;
    logic [WSUM_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [MEAN_W-1:0] quotient;
  } div_rsp_t;

  typedef struct packed {
    kind_t             kind;
    logic [MEAN_W-1:0] mean;
  } res_t;

  // Advance a ring position with wrap at the history depth.
  function automatic logic [POS_W-1:0] next_pos(input logic [POS_W-1:0] p);
    if (int'(p) >= HISTORY_DEPTH - 1) begin
      return '0;
    end
    return p + POS_W'(1);
  endfunction

  // Flat history address of one ring slot of one entry.
  function automatic logic [HADDR_W-1:0] hist_addr(input logic [ENTRY_W-1:0] e,
                                                   input logic [POS_W-1:0] p);
    return HADDR_W'(int'(e) * HISTORY_DEPTH + int'(p));
  endfunction

endpackage

// ===== hw/rtl/wrcs_cfg.sv =====
// APB register file holding the window length and the random threshold.
module wrcs_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [wrcs_pkg::PADDR_W-1:0] paddr,
  input  logic [wrcs_pkg::PDATA_W-1:0] pwdata,
  output logic [wrcs_pkg::PDATA_W-1:0] prdata,
  output logic                         pready,
  output wrcs_pkg::cfg_t               cfg
);

  logic [wrcs_pkg::WIN_W-1:0] window_r;
  logic [wrcs_pkg::THR_W-1:0] thresh_r;
  logic                       wr_en;

  // Complete a write in the access phase
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  // Hold the register values
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= wrcs_pkg::WINDOW_RESET;
      thresh_r <= '0;
    end else if (wr_en) begin
      if (paddr[2] == wrcs_pkg::REG_WINDOW) begin
        window_r <= pwdata[wrcs_pkg::WIN_W-1:0];
      end else begin
        thresh_r <= pwdata[wrcs_pkg::THR_W-1:0];
      end
    end
  end

  // Return the addressed register
  always_comb begin
    if (paddr[2] == wrcs_pkg::REG_WINDOW) begin
      prdata = wrcs_pkg::PDATA_W'(window_r);
    end else begin
      prdata = wrcs_pkg::PDATA_W'(thresh_r);
    end
  end

  assign cfg.window_length    = window_r;
  assign cfg.random_threshold = thresh_r;

endmodule

// ===== hw/rtl/wrcs_div.sv =====
// Restoring divider, one quotient bit per cycle, for the weighted mean.
module wrcs_div (
  input  logic               clk,
  input  logic               rst_n,
  input  wrcs_pkg::div_req_t req,
  output wrcs_pkg::div_rsp_t rsp
);

  logic                          busy_r;
  logic                          done_r;
  logic [wrcs_pkg::DCNT_W-1:0]   cnt_r;
  logic [wrcs_pkg::DIVD_W-1:0]   quo_r;
  logic [wrcs_pkg::WSUM_W-1:0]   rem_r;
  logic [wrcs_pkg::WSUM_W-1:0]   dsr_r;
  logic [wrcs_pkg::WSUM_W:0]     trial;
  logic                          fits;

  // Shift in the next dividend bit and try the subtraction
  assign trial = {rem_r, quo_r[wrcs_pkg::DIVD_W-1]};
  assign fits  = trial >= {1'b0, dsr_r};

  // Sequence the iterations
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == wrcs_pkg::DCNT_W'(1));
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= wrcs_pkg::DCNT_W'(wrcs_pkg::DIVD_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - wrcs_pkg::DCNT_W'(1);
        if (cnt_r == wrcs_pkg::DCNT_W'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // Advance remainder and quotient
  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r <= req.dividend;
      rem_r <= '0;
      dsr_r <= req.divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[wrcs_pkg::DIVD_W-2:0], fits};
      if (fits) begin
        rem_r <= wrcs_pkg::WSUM_W'(trial - {1'b0, dsr_r});
      end else begin
        rem_r <= trial[wrcs_pkg::WSUM_W-1:0];
      end
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r[wrcs_pkg::MEAN_W-1:0];

endmodule

// ===== hw/rtl/wrcs_ctrl.sv =====
// Command sequencer with the entry metadata memory and the history ring memory.
module wrcs_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [wrcs_pkg::CMD_W-1:0]  in_command,
  input  logic [wrcs_pkg::ALG_W-1:0]  in_algorithm_index,
  input  logic [wrcs_pkg::CONF_W-1:0] in_configuration_index,
  input  logic [wrcs_pkg::VAL_W-1:0]  in_inserted_count,
  input  logic [wrcs_pkg::RND_W-1:0]  in_random_value,
  input  wrcs_pkg::cfg_t              cfg,
  output wrcs_pkg::div_req_t          div_req,
  input  wrcs_pkg::div_rsp_t          div_rsp,
  output logic                        res_valid,
  output wrcs_pkg::res_t              res,
  input  logic                        res_take
);

  localparam int MEM_DEPTH = wrcs_pkg::ENTRIES * wrcs_pkg::HISTORY_DEPTH;

  // Memories
  wrcs_pkg::meta_t             meta_mem [wrcs_pkg::ENTRIES];
  logic [wrcs_pkg::VAL_W-1:0]  hist_mem [MEM_DEPTH];

  // Control state
  wrcs_pkg::state_t              state_r, state_nxt;
  logic [wrcs_pkg::TALLY_W-1:0]  tally_r, tally_nxt;
  logic [wrcs_pkg::ENTRIES-1:0]  meta_vld_r;

  // Transaction payload and datapath
  wrcs_pkg::cmd_t                cmd_r, cmd_nxt;
  logic [wrcs_pkg::ENTRY_W-1:0]  entry_r, entry_nxt;
  logic                          idx_ok_r, idx_ok_nxt;
  logic [wrcs_pkg::VAL_W-1:0]    ins_r, ins_nxt;
  logic [wrcs_pkg::RND_W-1:0]    rnd_r, rnd_nxt;
  wrcs_pkg::meta_t               meta_rd_r;
  logic [wrcs_pkg::VAL_W-1:0]    hist_rd_r;
  logic [wrcs_pkg::POS_W-1:0]    pos_r, pos_nxt;
  logic [wrcs_pkg::FILL_W-1:0]   idx_r, idx_nxt;
  logic [wrcs_pkg::FILL_W-1:0]   k_r, k_nxt;
  logic [wrcs_pkg::SUM_W-1:0]    sum_r, sum_nxt;
  logic [wrcs_pkg::WSUM_W-1:0]   wsum_r, wsum_nxt;
  wrcs_pkg::kind_t               kind_r, kind_nxt;
  logic [wrcs_pkg::MEAN_W-1:0]   mean_r, mean_nxt;

  // Memory ports
  logic                          meta_we;
  wrcs_pkg::meta_t               meta_wd;
  logic [wrcs_pkg::ENTRY_W-1:0]  meta_ra;
  logic                          hist_we;
  logic [wrcs_pkg::HADDR_W-1:0]  hist_wa;
  logic [wrcs_pkg::HADDR_W-1:0]  hist_ra;

  // Helpers
  wrcs_pkg::meta_t               meta_cur;
  logic                          accept;
  logic                          in_ok;
  logic [wrcs_pkg::WIN_W-1:0]    win_eff;
  logic [wrcs_pkg::FILL_W-1:0]   k_sel;
  logic [wrcs_pkg::POS_W-1:0]    pos_start;
  logic [wrcs_pkg::FILL_W-1:0]   weight;
  logic [wrcs_pkg::SUM_W-1:0]    prod;
  int                            start_i;

  assign accept   = in_valid && !in_stall;
  assign in_stall = state_r != wrcs_pkg::ST_IDLE;
  assign in_ok    = (int'(in_algorithm_index) < wrcs_pkg::NUM_ALGORITHMS) &&
                    (int'(in_configuration_index) < wrcs_pkg::NUM_CONFIGURATIONS);
  assign meta_ra  = in_ok ? wrcs_pkg::ENTRY_W'(int'(in_algorithm_index) *
                                               wrcs_pkg::NUM_CONFIGURATIONS +
                                               int'(in_configuration_index))
                          : '0;

  // Entries never written read as the reset value
  assign meta_cur = meta_vld_r[entry_r] ? meta_rd_r : '0;

  // Window size and oldest ring slot of the window
  always_comb begin
    start_i = 0;
    if (cfg.window_length == '0) begin
      win_eff = wrcs_pkg::WIN_W'(1);
    end else begin
      win_eff = cfg.window_length;
    end
    if (int'(win_eff) > int'(meta_cur.fill)) begin
      k_sel = meta_cur.fill;
    end else begin
      k_sel = wrcs_pkg::FILL_W'(win_eff);
    end
    start_i = int'(meta_cur.wptr) + wrcs_pkg::HISTORY_DEPTH - int'(k_sel);
    if (start_i >= wrcs_pkg::HISTORY_DEPTH) begin
      pos_start = wrcs_pkg::POS_W'(start_i - wrcs_pkg::HISTORY_DEPTH);
    end else begin
      pos_start = wrcs_pkg::POS_W'(start_i);
    end
  end

  // Weighted term of the current history word
  assign weight = idx_r + wrcs_pkg::FILL_W'(1);
  assign prod   = wrcs_pkg::SUM_W'(hist_rd_r) * wrcs_pkg::SUM_W'(weight);

  // Next state, memory strobes and datapath updates
  always_comb begin
    state_nxt  = state_r;
    tally_nxt  = tally_r;
    cmd_nxt    = cmd_r;
    entry_nxt  = entry_r;
    idx_ok_nxt = idx_ok_r;
    ins_nxt    = ins_r;
    rnd_nxt    = rnd_r;
    pos_nxt    = pos_r;
    idx_nxt    = idx_r;
    k_nxt      = k_r;
    sum_nxt    = sum_r;
    wsum_nxt   = wsum_r;
    kind_nxt   = kind_r;
    mean_nxt   = mean_r;
    meta_we    = 1'b0;
    meta_wd    = meta_cur;
    hist_we    = 1'b0;
    hist_wa    = wrcs_pkg::hist_addr(entry_r, meta_cur.wptr);
    hist_ra    = '0;
    res_valid  = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = {sum_r, wrcs_pkg::FRAC_W'(0)};
    div_req.divisor  = wsum_r;

    unique case (state_r)
      wrcs_pkg::ST_IDLE: begin
        // Capture the transaction; the metadata read is issued at this edge
        if (accept) begin
          cmd_nxt    = wrcs_pkg::cmd_t'(in_command);
          entry_nxt  = meta_ra;
          idx_ok_nxt = in_ok;
          ins_nxt    = in_inserted_count;
          rnd_nxt    = in_random_value;
          state_nxt  = wrcs_pkg::ST_META;
        end
      end

      wrcs_pkg::ST_META: begin
        state_nxt = wrcs_pkg::ST_IDLE;
        unique case (cmd_r)
          wrcs_pkg::CMD_BEGIN: begin
            // Raise the running count, saturating
            meta_we = idx_ok_r;
            if (int'(meta_cur.running) < wrcs_pkg::RUN_MAX) begin
              meta_wd.running = meta_cur.running + wrcs_pkg::RUN_W'(1);
            end
          end
          wrcs_pkg::CMD_END: begin
            // Lower the running count and count one finish
            meta_we = idx_ok_r;
            if (meta_cur.running != '0) begin
              meta_wd.running = meta_cur.running - wrcs_pkg::RUN_W'(1);
            end
            if (tally_r < wrcs_pkg::TALLY_W'(2)) begin
              tally_nxt = tally_r + wrcs_pkg::TALLY_W'(1);
            end
          end
          wrcs_pkg::CMD_RECORD: begin
            // Append to the ring once two finishes have been seen
            if (idx_ok_r && tally_r > wrcs_pkg::TALLY_W'(1)) begin
              hist_we      = 1'b1;
              meta_we      = 1'b1;
              meta_wd.wptr = wrcs_pkg::next_pos(meta_cur.wptr);
              if (int'(meta_cur.fill) < wrcs_pkg::HISTORY_DEPTH) begin
                meta_wd.fill = meta_cur.fill + wrcs_pkg::FILL_W'(1);
              end
            end
          end
          wrcs_pkg::CMD_ESTIMATE: begin
            // Classify the entry, or start the walk over the window
            mean_nxt  = '0;
            state_nxt = wrcs_pkg::ST_EMIT;
            if (!idx_ok_r) begin
              kind_nxt = wrcs_pkg::KIND_HUGE;
            end else if (meta_cur.fill == '0) begin
              kind_nxt = (meta_cur.running == '0) ? wrcs_pkg::KIND_HUGE
                                                  : wrcs_pkg::KIND_TINY;
            end else if (rnd_r < cfg.random_threshold) begin
              kind_nxt = wrcs_pkg::KIND_ONE;
            end else begin
              kind_nxt  = wrcs_pkg::KIND_MEAN;
              k_nxt     = k_sel;
              idx_nxt   = '0;
              pos_nxt   = pos_start;
              sum_nxt   = '0;
              wsum_nxt  = '0;
              hist_ra   = wrcs_pkg::hist_addr(entry_r, pos_start);
              state_nxt = wrcs_pkg::ST_SUM;
            end
          end
          default: begin
            state_nxt = wrcs_pkg::ST_IDLE;
          end
        endcase
      end

      wrcs_pkg::ST_SUM: begin
        // Accumulate one word per cycle, oldest first with weight one
        sum_nxt  = sum_r + prod;
        wsum_nxt = wsum_r + wrcs_pkg::WSUM_W'(weight);
        pos_nxt  = wrcs_pkg::next_pos(pos_r);
        idx_nxt  = weight;
        hist_ra  = wrcs_pkg::hist_addr(entry_r, wrcs_pkg::next_pos(pos_r));
        if (weight == k_r) begin
          state_nxt = wrcs_pkg::ST_START;
        end
      end

      wrcs_pkg::ST_START: begin
        // Launch the division of the scaled sum by the weight sum
        div_req.start = 1'b1;
        state_nxt     = wrcs_pkg::ST_DIV;
      end

      wrcs_pkg::ST_DIV: begin
        if (div_rsp.done) begin
          mean_nxt  = div_rsp.quotient;
          state_nxt = wrcs_pkg::ST_EMIT;
        end
      end

      wrcs_pkg::ST_EMIT: begin
        // Hand the result over once the output register is free or being drained
        res_valid = 1'b1;
        if (res_take) begin
          state_nxt = wrcs_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = wrcs_pkg::ST_IDLE;
      end
    endcase
  end

  assign res.kind = kind_r;
  assign res.mean = mean_r;

  // State register and control flops
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= wrcs_pkg::ST_IDLE;
      tally_r    <= '0;
      meta_vld_r <= '0;
    end else begin
      state_r <= state_nxt;
      tally_r <= tally_nxt;
      if (meta_we) begin
        meta_vld_r[entry_r] <= 1'b1;
      end
    end
  end

  // Payload and datapath registers
  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    entry_r  <= entry_nxt;
    idx_ok_r <= idx_ok_nxt;
    ins_r    <= ins_nxt;
    rnd_r    <= rnd_nxt;
    pos_r    <= pos_nxt;
    idx_r    <= idx_nxt;
    k_r      <= k_nxt;
    sum_r    <= sum_nxt;
    wsum_r   <= wsum_nxt;
    kind_r   <= kind_nxt;
    mean_r   <= mean_nxt;
  end

  // Entry metadata memory
  always_ff @(posedge clk) begin
    if (meta_we) begin
      meta_mem[entry_r] <= meta_wd;
    end
    meta_rd_r <= meta_mem[meta_ra];
  end

  // History ring memory
  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist_mem[hist_wa] <= ins_r;
    end
    hist_rd_r <= hist_mem[hist_ra];
  end

endmodule

// ===== hw/rtl/weighted_recent_contribution_score.sv =====
// Weighted recent contribution score: one transaction is taken at a time. Begin, end and
// record read the entry metadata, then write it back. Estimate without a mean goes from
// the metadata read to the result; with a mean it sums k history words, k being the window
// used (at most 16), then divides the 32-bit scaled sum by the weight sum: the history
// memory gives one word per cycle and the divider one quotient bit per cycle. The result
// is held in an output register, so the block returns to idle while the result waits on
// out_stall, unless an earlier result still fills that register. History words are read
// only below the entry's fill count, so no clearing pass runs after reset and
// transactions are taken from the first cycle out of reset.
module weighted_recent_contribution_score (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [wrcs_pkg::CMD_W-1:0]   in_command,
  input  logic [wrcs_pkg::ALG_W-1:0]   in_algorithm_index,
  input  logic [wrcs_pkg::CONF_W-1:0]  in_configuration_index,
  input  logic [wrcs_pkg::VAL_W-1:0]   in_inserted_count,
  input  logic [wrcs_pkg::RND_W-1:0]   in_random_value,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [wrcs_pkg::KIND_W-1:0]  out_score_kind,
  output logic [wrcs_pkg::MEAN_W-1:0]  out_weighted_mean,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [wrcs_pkg::PADDR_W-1:0] paddr,
  input  logic [wrcs_pkg::PDATA_W-1:0] pwdata,
  output logic [wrcs_pkg::PDATA_W-1:0] prdata,
  output logic                         pready
);

  wrcs_pkg::cfg_t              cfg;
  wrcs_pkg::div_req_t          div_req;
  wrcs_pkg::div_rsp_t          div_rsp;
  wrcs_pkg::res_t              res;
  logic                        res_valid;
  logic                        res_take;
  logic                        out_valid_r;
  logic [wrcs_pkg::KIND_W-1:0] out_kind_r;
  logic [wrcs_pkg::MEAN_W-1:0] out_mean_r;

  wrcs_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  wrcs_ctrl u_ctrl (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_command             (in_command),
    .in_algorithm_index     (in_algorithm_index),
    .in_configuration_index (in_configuration_index),
    .in_inserted_count      (in_inserted_count),
    .in_random_value        (in_random_value),
    .cfg                    (cfg),
    .div_req                (div_req),
    .div_rsp                (div_rsp),
    .res_valid              (res_valid),
    .res                    (res),
    .res_take               (res_take)
  );

  wrcs_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Take a new result when the output register is empty or being drained
  assign res_take = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= res_valid;
    end
  end

  // Load the result payload
  always_ff @(posedge clk) begin
    if (res_take && res_valid) begin
      out_kind_r <= res.kind;
      out_mean_r <= res.mean;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_score_kind    = out_kind_r;
  assign out_weighted_mean = out_mean_r;

endmodule

// ===== hw/rtl/wrcs_chk.sv =====
// Port-level checker of the recent contribution score block and its bind.
`include "weighted_recent_contribution_score_macros.svh"

module wrcs_chk (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [wrcs_pkg::KIND_W-1:0]  out_score_kind,
  input logic [wrcs_pkg::MEAN_W-1:0]  out_weighted_mean
);

  // Result channel is empty right after reset
  `WRCS_ASSERT_ALWAYS(a_out_empty_after_reset, !rst_n |=> !out_valid, "result valid after reset")

  // A stalled result keeps its payload
  `WRCS_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_score_kind) && $stable(out_weighted_mean), "stalled result changed")

  // Only the mean kind carries a nonzero mean
  `WRCS_ASSERT(a_mean_zero, out_valid && out_score_kind != wrcs_pkg::KIND_MEAN |-> out_weighted_mean == '0, "mean set on a non-mean kind")

  // One transaction at a time: input stalls right after a transaction
  `WRCS_ASSERT(a_one_at_a_time, in_valid && !in_stall |=> in_stall, "input taken back to back")

endmodule

bind weighted_recent_contribution_score wrcs_chk u_chk (.*);
